// ===== hdl/lnx_pkg.sv =====
// ----------------------------------------------------------------------------
// lnx_pkg
// Shared constants and types for the line intersection pipeline.
// ----------------------------------------------------------------------------
package lnx_pkg;

    // default coordinate width and fraction bits of the result
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // width of one result coordinate
    localparam int OUT_W = 48;

    // result flags in tuser
    localparam int USER_W    = 2;
    localparam int USER_FOUND = 0;
    localparam int USER_CLIP  = 1;

    // pipeline control handed to every stage
    typedef struct packed {
        logic en;     // all stages advance
        logic valid;  // request present at stage input
    } t_pipe_ctl;

endpackage

// ===== hdl/lnx_coef.sv =====
// ----------------------------------------------------------------------------
// lnx_coef
// Four-stage pipeline forming line coefficients and the determinants D, Dx, Dy.
// ----------------------------------------------------------------------------
module lnx_coef #(
    parameter int COORD_WIDTH = lnx_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lnx_pkg::t_pipe_ctl                    i_ctl,
    input  logic [8*COORD_WIDTH-1:0]              i_pts,
    output logic                                  o_valid,
    output logic signed [2*COORD_WIDTH+2:0]       o_det,
    output logic signed [3*COORD_WIDTH+2:0]       o_det_x,
    output logic signed [3*COORD_WIDTH+2:0]       o_det_y
);

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = CW + 1;
    localparam int CCW = 2 * CW + 1;
    localparam int DW  = 2 * CW + 3;
    localparam int PW  = CCW + AW;
    localparam int NW  = PW + 1;

    logic signed [CW-1:0] sx1, sy1, ex1, ey1, sx2, sy2, ex2, ey2;

    // unpack the point coordinates
    assign sx1 = i_pts[0*CW +: CW];
    assign sy1 = i_pts[1*CW +: CW];
    assign ex1 = i_pts[2*CW +: CW];
    assign ey1 = i_pts[3*CW +: CW];
    assign sx2 = i_pts[4*CW +: CW];
    assign sy2 = i_pts[5*CW +: CW];
    assign ex2 = i_pts[6*CW +: CW];
    assign ey2 = i_pts[7*CW +: CW];

    logic                   r_v1, r_v2, r_v3, r_v4;
    logic signed [AW-1:0]   r_a1, r_b1, r_a2, r_b2;
    logic signed [2*CW-1:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [AW-1:0]   r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [CCW-1:0]  r_c1, r_c2;
    logic signed [2*AW-1:0] r_mab, r_mba;
    logic signed [DW-1:0]   r_d3, r_d4;
    logic signed [PW-1:0]   r_q1, r_q2, r_q3, r_q4;
    logic signed [NW-1:0]   r_dx, r_dy;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 1: differences and cross products of the endpoints
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a1 <= AW'(sy1) - AW'(ey1);
            r_b1 <= AW'(ex1) - AW'(sx1);
            r_a2 <= AW'(sy2) - AW'(ey2);
            r_b2 <= AW'(ex2) - AW'(sx2);
            r_p1 <= ex1 * sy1;
            r_p2 <= sx1 * ey1;
            r_p3 <= ex2 * sy2;
            r_p4 <= sx2 * ey2;
        end
    end

    // stage 2: c terms and the products for D
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_c1  <= CCW'(r_p1) - CCW'(r_p2);
            r_c2  <= CCW'(r_p3) - CCW'(r_p4);
            r_mab <= r_a1 * r_b2;
            r_mba <= r_b1 * r_a2;
            r2_a1 <= r_a1;
            r2_b1 <= r_b1;
            r2_a2 <= r_a2;
            r2_b2 <= r_b2;
        end
    end

    // stage 3: D and the products for Dx and Dy
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_d3 <= DW'(r_mab) - DW'(r_mba);
            r_q1 <= PW'(r_c1) * PW'(r2_b2);
            r_q2 <= PW'(r2_b1) * PW'(r_c2);
            r_q3 <= PW'(r2_a1) * PW'(r_c2);
            r_q4 <= PW'(r_c1) * PW'(r2_a2);
        end
    end

    // stage 4: Dx and Dy
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_d4 <= r_d3;
            r_dx <= NW'(r_q1) - NW'(r_q2);
            r_dy <= NW'(r_q3) - NW'(r_q4);
        end
    end

    assign o_valid = r_v4;
    assign o_det   = r_d4;
    assign o_det_x = r_dx;
    assign o_det_y = r_dy;

endmodule

// ===== hdl/lnx_div.sv =====
// ----------------------------------------------------------------------------
// lnx_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module lnx_div #(
    parameter int NW = 51,
    parameter int DW = 35,
    parameter int FB = lnx_pkg::FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lnx_pkg::t_pipe_ctl             i_ctl,
    input  logic signed [NW-1:0]           i_num,
    input  logic signed [DW-1:0]           i_den,
    output logic                           o_valid,
    output logic                           o_zero,
    output logic                           o_clip,
    output logic [lnx_pkg::OUT_W-1:0]      o_quot
);

    localparam int MW = NW + FB;
    localparam int OW = lnx_pkg::OUT_W;
    localparam int SW = MW + OW;

    logic [NW:0] num_mag;
    logic [DW:0] den_mag;

    // magnitudes of numerator and denominator
    assign num_mag = i_num[NW-1] ? (NW+1)'(0) - (NW+1)'(i_num) : (NW+1)'(i_num);
    assign den_mag = i_den[DW-1] ? (DW+1)'(0) - (DW+1)'(i_den) : (DW+1)'(i_den);

    logic          r_v   [0:MW];
    logic          r_neg [0:MW];
    logic          r_zer [0:MW];
    logic [DW-1:0] r_rem [0:MW];
    logic [MW-1:0] r_num [0:MW];
    logic [MW-1:0] r_q   [0:MW];
    logic [DW-1:0] r_den [0:MW];

    // prep stage: signs, scaled magnitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_v[0] <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_neg[0] <= i_num[NW-1] ^ i_den[DW-1];
            r_zer[0] <= (i_den == '0);
            r_rem[0] <= '0;
            r_num[0] <= MW'(num_mag[NW-1:0]) << FB;
            r_q[0]   <= '0;
            r_den[0] <= den_mag[DW-1:0];
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < MW; k++) begin : g_step
        logic [DW:0] trial;
        logic        ge;

        assign trial = {r_rem[k], r_num[k][MW-1]};
        assign ge    = (trial >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_neg[k+1] <= r_neg[k];
                r_zer[k+1] <= r_zer[k];
                r_den[k+1] <= r_den[k];
                r_num[k+1] <= r_num[k] << 1;
                r_q[k+1]   <= {r_q[k][MW-2:0], ge};
                r_rem[k+1] <= ge ? DW'(trial - {1'b0, r_den[k]}) : DW'(trial);
            end
        end
    end

    logic [SW-1:0] q_ext, lim_ext;
    logic [OW-1:0] lim, sat_mag;
    logic          clip;

    // saturate to the output range and apply the sign
    assign lim     = r_neg[MW] ? (OW'(1) << (OW-1)) : ((OW'(1) << (OW-1)) - OW'(1));
    assign q_ext   = SW'(r_q[MW]);
    assign lim_ext = SW'(lim);
    assign clip    = (q_ext > lim_ext);
    assign sat_mag = clip ? lim : q_ext[OW-1:0];

    logic          r_vo, r_zo, r_co;
    logic [OW-1:0] r_qo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_ctl.en) begin
            r_vo <= r_v[MW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_zo <= r_zer[MW];
            r_co <= clip;
            r_qo <= r_neg[MW] ? OW'(0) - sat_mag : sat_mag;
        end
    end

    assign o_valid = r_vo;
    assign o_zero  = r_zo;
    assign o_clip  = r_co;
    assign o_quot  = r_qo;

endmodule

// ===== hdl/line_intersection.sv =====
// ----------------------------------------------------------------------------
// line_intersection
// Intersection of two lines by Cramer's rule in signed fixed point.
// ----------------------------------------------------------------------------
// One request on the s channel carries two lines, each as two points:
// tdata holds line1 start x/y, line1 end x/y, line2 start x/y, line2 end x/y,
// COORD_WIDTH bits each, lowest field first. Each request yields one result
// on the m channel: tdata holds cross_x then cross_y (48 bits each, signed,
// FRACTION_BITS fraction bits, truncated toward zero); tuser bit 0 is found
// and bit 1 is clipped. When the lines are parallel or degenerate, found is 0
// and all other fields are 0.
// The pipeline is four determinant stages, a prep stage, one divider stage
// per quotient bit, a saturation stage and the output register. Throughput
// is one request per cycle while the receiver does not stall; the
// quotient-bit divider stages set the latency.
// A synchronous active-low reset empties the pipeline. When the receiver
// stalls, the whole pipeline holds and s tready drops in the same cycle;
// nothing is lost or repeated.
module line_intersection #(
    parameter int COORD_WIDTH   = lnx_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = lnx_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // line1_start_x, line1_start_y, line1_end_x, line1_end_y,
    // line2_start_x, line2_start_y, line2_end_x, line2_end_y
    input  logic [8*COORD_WIDTH-1:0]         i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // cross_x, cross_y
    output logic [2*lnx_pkg::OUT_W-1:0]      o_m_tdata,
    // found, clipped
    output logic [lnx_pkg::USER_W-1:0]       o_m_tuser
);

    localparam int DW = 2 * COORD_WIDTH + 3;
    localparam int NW = 3 * COORD_WIDTH + 3;
    localparam int OW = lnx_pkg::OUT_W;

    lnx_pkg::t_pipe_ctl in_ctl, div_ctl;
    logic               en;
    logic               r_out_valid;

    // global advance: output register empty or being taken
    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    assign in_ctl.en     = en;
    assign in_ctl.valid  = i_s_tvalid;

    logic                 coef_valid;
    logic signed [DW-1:0] det;
    logic signed [NW-1:0] det_x, det_y;

    lnx_coef #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_pts   (i_s_tdata),
        .o_valid (coef_valid),
        .o_det   (det),
        .o_det_x (det_x),
        .o_det_y (det_y)
    );

    assign div_ctl.en    = en;
    assign div_ctl.valid = coef_valid;

    logic          vx, vy, zx, zy, cx, cy;
    logic [OW-1:0] qx, qy;

    lnx_div #(
        .NW (NW),
        .DW (DW),
        .FB (FRACTION_BITS)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (det_x),
        .i_den   (det),
        .o_valid (vx),
        .o_zero  (zx),
        .o_clip  (cx),
        .o_quot  (qx)
    );

    lnx_div #(
        .NW (NW),
        .DW (DW),
        .FB (FRACTION_BITS)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (det_y),
        .i_den   (det),
        .o_valid (vy),
        .o_zero  (zy),
        .o_clip  (cy),
        .o_quot  (qy)
    );

    logic [OW-1:0] r_x, r_y;
    logic          r_found, r_clip;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= vx & vy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_found <= !zx;
            r_clip  <= !zy && (cx || cy);
            r_x     <= zx ? '0 : qx;
            r_y     <= zy ? '0 : qy;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_y, r_x};
    assign o_m_tuser  = {r_clip, r_found};

endmodule

// ===== hdl/lnx_check.sv =====
// ----------------------------------------------------------------------------
// lnx_check
// Port-level checks for line_intersection, bound to the top level.
// ----------------------------------------------------------------------------
module lnx_check (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [2*lnx_pkg::OUT_W-1:0]      o_m_tdata,
    input logic [lnx_pkg::USER_W-1:0]       o_m_tuser
);

    localparam int OW = lnx_pkg::OUT_W;
    localparam logic [OW-1:0] MAXV = (OW'(1) << (OW-1)) - OW'(1);
    localparam logic [OW-1:0] MINV = OW'(1) << (OW-1);

    // pipeline is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result changed");

    // input side is held exactly while the output is stalled
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    // no intersection gives all-zero fields
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[lnx_pkg::USER_FOUND] |->
            o_m_tdata == '0 && !o_m_tuser[lnx_pkg::USER_CLIP])
        else $error("parallel lines with nonzero result");

    // a clipped result sits on a range limit
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[lnx_pkg::USER_CLIP] |->
            o_m_tdata[OW-1:0] == MAXV || o_m_tdata[OW-1:0] == MINV
            || o_m_tdata[2*OW-1:OW] == MAXV || o_m_tdata[2*OW-1:OW] == MINV)
        else $error("clipped result off the range limits");

endmodule

bind line_intersection lnx_check u_lnx_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
